// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== hdl/jcs_pkg.sv =====
package jcs_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_STRING     = 3'd1,
    MODE_SLASH      = 3'd2,
    MODE_LINE       = 3'd3,
    MODE_BLOCK      = 3'd4,
    MODE_BLOCK_STAR = 3'd5
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_END_OK   = 2'd1;
  localparam logic [1:0] KIND_END_OPEN = 2'd2;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;
  } result_t;

  typedef struct packed {
    mode_t      mode_next;
    logic [1:0] count;
    result_t [MAX_RESULTS-1:0] res;
  } scan_t;

endpackage

// ===== hdl/jcs_scanner.sv =====
module jcs_scanner (
  input  jcs_pkg::mode_t mode,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output jcs_pkg::scan_t scan
);

  logic [1:0]     emit;
  logic [7:0]     b0;
  logic [7:0]     b1;
  jcs_pkg::mode_t nxt;
  jcs_pkg::result_t end_item;

  always_comb begin
    emit = 2'd0;
    b0   = in_byte;
    b1   = in_byte;
    nxt  = mode;
    case (mode)
      jcs_pkg::MODE_STRING: begin
        emit = 2'd1;
        nxt  = (in_byte == jcs_pkg::CH_QUOTE) ? jcs_pkg::MODE_NORMAL : jcs_pkg::MODE_STRING;
      end
      jcs_pkg::MODE_SLASH: begin
        if (in_byte == jcs_pkg::CH_SLASH) begin
          nxt = jcs_pkg::MODE_LINE;
        end else if (in_byte == jcs_pkg::CH_STAR) begin
          nxt = jcs_pkg::MODE_BLOCK_STAR;
        end else begin
          emit = 2'd2;
          b0   = jcs_pkg::CH_SLASH;
          nxt  = jcs_pkg::MODE_NORMAL;
        end
      end
      jcs_pkg::MODE_LINE: begin
        if (in_byte == jcs_pkg::CH_NL) begin
          emit = 2'd1;
          nxt  = jcs_pkg::MODE_NORMAL;
        end
      end
      jcs_pkg::MODE_BLOCK: begin
        if (in_byte == jcs_pkg::CH_STAR) nxt = jcs_pkg::MODE_BLOCK_STAR;
      end
      jcs_pkg::MODE_BLOCK_STAR: begin
        if (in_byte == jcs_pkg::CH_SLASH) nxt = jcs_pkg::MODE_NORMAL;
        else if (in_byte != jcs_pkg::CH_STAR) nxt = jcs_pkg::MODE_BLOCK;
      end
      default: begin
        if (in_byte == jcs_pkg::CH_SLASH) begin
          nxt = jcs_pkg::MODE_SLASH;
        end else begin
          emit = 2'd1;
          nxt  = (in_byte == jcs_pkg::CH_QUOTE) ? jcs_pkg::MODE_STRING : jcs_pkg::MODE_NORMAL;
        end
      end
    endcase
  end

  always_comb begin
    scan.mode_next = nxt;
    scan.count     = emit;
    for (int i = 0; i < jcs_pkg::MAX_RESULTS; i++) begin
      scan.res[i] = '{out_byte: 8'd0, kind: jcs_pkg::KIND_BYTE, run_last: 1'b0};
    end
    scan.res[0].out_byte = b0;
    scan.res[1].out_byte = b1;
    end_item = '{out_byte: 8'd0, kind: jcs_pkg::KIND_END_OK, run_last: 1'b0};
    if (nxt == jcs_pkg::MODE_STRING || nxt == jcs_pkg::MODE_LINE ||
        nxt == jcs_pkg::MODE_BLOCK || nxt == jcs_pkg::MODE_BLOCK_STAR) begin
      end_item.kind = jcs_pkg::KIND_END_OPEN;
    end
    if (in_last) begin
      scan.mode_next = jcs_pkg::MODE_NORMAL;
      if (nxt == jcs_pkg::MODE_SLASH) begin
        // held slash is released ahead of the end beat
        scan.res[0].out_byte = jcs_pkg::CH_SLASH;
        scan.res[1]          = end_item;
        scan.count           = 2'd2;
      end else begin
        case (emit)
          2'd0:    scan.res[0] = end_item;
          2'd1:    scan.res[1] = end_item;
          default: scan.res[2] = end_item;
        endcase
        scan.count = emit + 2'd1;
      end
    end
    for (int i = 0; i < jcs_pkg::MAX_RESULTS; i++) begin
      scan.res[i].run_last = (2'(i + 1) == scan.count);
    end
  end

endmodule

// ===== hdl/json_comment_stripper.sv =====
// JSON comment stripper.
// Input channel (in_valid/in_ready): one text byte per beat in in_byte, in_last
// marks the final byte of a text. Output channel (out_valid/out_ready): one
// result per beat; kind 0 carries a kept byte in out_byte, kind 1 ends a text
// cleanly, kind 2 ends a text with a string or comment still open. run_last
// flags the last result caused by an input byte; a byte may cause 0 to 3.
// Latency: with the queue empty, the first result of a byte is offered on the
// cycle after its beat; otherwise it waits behind the queued results.
// Throughput: one byte per cycle while each byte yields at most one result and the receiver takes every result.
// Results go through a QDEPTH-entry result queue; in_ready is high while at
// least three entries are free, so a lone slash releasing two bytes, or an
// end beat, may drop in_ready while the queue drains.
// A stalled receiver backs up the queue until in_ready drops; nothing is lost.
// Reset (rst, synchronous): scan mode returns to normal text, queue empties.
`include "assert_macros.svh"

module json_comment_stripper #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       run_last
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  jcs_pkg::mode_t   mode;
  jcs_pkg::scan_t   scan;
  jcs_pkg::result_t queue [QDEPTH];
  jcs_pkg::result_t head;

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] rd_ptr_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    push_n;
  logic          in_fire;
  logic          pop;
  logic [PW-1:0] slot [jcs_pkg::MAX_RESULTS];

  jcs_scanner u_scanner (
    .mode    (mode),
    .in_byte (in_byte),
    .in_last (in_last),
    .scan    (scan)
  );

  assign in_ready = (count <= CW'(QDEPTH - jcs_pkg::MAX_RESULTS));
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;
  assign push_n   = in_fire ? scan.count : 2'd0;

  always_comb begin
    for (int i = 0; i < jcs_pkg::MAX_RESULTS; i++) begin
      if ((PW + 1)'(wr_ptr) + (PW + 1)'(i) >= (PW + 1)'(QDEPTH)) begin
        slot[i] = PW'((PW + 1)'(wr_ptr) + (PW + 1)'(i) - (PW + 1)'(QDEPTH));
      end else begin
        slot[i] = PW'((PW + 1)'(wr_ptr) + (PW + 1)'(i));
      end
    end
    if ((PW + 1)'(wr_ptr) + (PW + 1)'(push_n) >= (PW + 1)'(QDEPTH)) begin
      wr_ptr_next = PW'((PW + 1)'(wr_ptr) + (PW + 1)'(push_n) - (PW + 1)'(QDEPTH));
    end else begin
      wr_ptr_next = PW'((PW + 1)'(wr_ptr) + (PW + 1)'(push_n));
    end
    if (!pop) begin
      rd_ptr_next = rd_ptr;
    end else if (rd_ptr == PW'(QDEPTH - 1)) begin
      rd_ptr_next = '0;
    end else begin
      rd_ptr_next = rd_ptr + PW'(1);
    end
    count_next = count + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= jcs_pkg::MODE_NORMAL;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) mode <= scan.mode_next;
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < jcs_pkg::MAX_RESULTS; i++) begin
      if (in_fire && (2'(i) < scan.count)) queue[slot[i]] <= scan.res[i];
    end
  end

  assign head     = queue[rd_ptr];
  assign out_byte = head.out_byte;
  assign kind     = head.kind;
  assign run_last = head.run_last;

  `ASSERT_CLK(a_count_bound, clk, rst, count <= CW'(QDEPTH), "result queue overflow")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "queue not empty after reset")
  `ASSERT_CLK(a_room_on_accept, clk, rst,
      in_fire |-> (count <= CW'(QDEPTH - jcs_pkg::MAX_RESULTS)), "accept without room")
  `ASSERT_CLK(a_count_track, clk, rst,
      1'b1 |=> (count == $past(count) + CW'($past(push_n)) - CW'($past(pop))),
      "queue count mismatch")
  `ASSERT_CLK(a_last_resets_mode, clk, rst,
      (in_fire && in_last) |=> (mode == jcs_pkg::MODE_NORMAL), "mode not reset after end")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int N_DIR      = 25;
  localparam int N_RAND     = 395;
  localparam int QUIET_TAIL = 60;
  localparam int LONG_HOLD  = 80;
  localparam int WD_LIMIT   = 1000;

  localparam jcs_pkg::result_t NO_RES = '0;

  typedef struct packed {
    logic [7:0]              data;
    logic                    last;
    logic                    typed;
    logic [1:0]              n;
    jcs_pkg::result_t [1:0]  res;
  } beat_t;

  typedef enum int {TOK_PLAIN, TOK_STRING, TOK_LINE, TOK_BLOCK, TOK_SLASH} tok_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;

  beat_t            dir_tab [N_DIR];
  beat_t            stim [$];
  jcs_pkg::result_t due_results [$];
  jcs_pkg::mode_t   scan_state = jcs_pkg::MODE_NORMAL;
  jcs_pkg::result_t step_res [jcs_pkg::MAX_RESULTS];
  int               step_cnt;
  int               bytes_taken = 0;
  int               fail_cnt = 0;
  int               idle_cycles = 0;
  bit               quiet = 1'b0;

  json_comment_stripper u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .kind     (kind),
    .run_last (run_last)
  );

  always #5 clk = ~clk;

  function automatic jcs_pkg::result_t mk_res(logic [7:0] b, logic [1:0] k, logic l);
    jcs_pkg::result_t r;
    r.out_byte = b;
    r.kind     = k;
    r.run_last = l;
    return r;
  endfunction

  function automatic beat_t row(logic [7:0] d, logic l, logic t, logic [1:0] n,
                                jcs_pkg::result_t r0, jcs_pkg::result_t r1);
    beat_t r;
    r.data   = d;
    r.last   = l;
    r.typed  = t;
    r.n      = n;
    r.res[0] = r0;
    r.res[1] = r1;
    return r;
  endfunction

  function automatic void emit(logic [7:0] b, logic [1:0] k);
    step_res[step_cnt] = mk_res(b, k, 1'b0);
    step_cnt++;
  endfunction

  // Advance the scanner by one byte; fills step_res/step_cnt.
  function automatic void strip_byte(logic [7:0] c, logic last);
    step_cnt = 0;
    case (scan_state)
      jcs_pkg::MODE_STRING: begin
        emit(c, jcs_pkg::KIND_BYTE);
        if (c == jcs_pkg::CH_QUOTE) scan_state = jcs_pkg::MODE_NORMAL;
      end
      jcs_pkg::MODE_SLASH: begin
        if (c == jcs_pkg::CH_SLASH) begin
          scan_state = jcs_pkg::MODE_LINE;
        end else if (c == jcs_pkg::CH_STAR) begin
          scan_state = jcs_pkg::MODE_BLOCK_STAR;
        end else begin
          emit(jcs_pkg::CH_SLASH, jcs_pkg::KIND_BYTE);
          emit(c, jcs_pkg::KIND_BYTE);
          scan_state = jcs_pkg::MODE_NORMAL;
        end
      end
      jcs_pkg::MODE_LINE: begin
        if (c == jcs_pkg::CH_NL) begin
          emit(c, jcs_pkg::KIND_BYTE);
          scan_state = jcs_pkg::MODE_NORMAL;
        end
      end
      jcs_pkg::MODE_BLOCK: begin
        if (c == jcs_pkg::CH_STAR) scan_state = jcs_pkg::MODE_BLOCK_STAR;
      end
      jcs_pkg::MODE_BLOCK_STAR: begin
        if (c == jcs_pkg::CH_SLASH) scan_state = jcs_pkg::MODE_NORMAL;
        else if (c != jcs_pkg::CH_STAR) scan_state = jcs_pkg::MODE_BLOCK;
      end
      default: begin
        if (c == jcs_pkg::CH_SLASH) begin
          scan_state = jcs_pkg::MODE_SLASH;
        end else begin
          emit(c, jcs_pkg::KIND_BYTE);
          scan_state = (c == jcs_pkg::CH_QUOTE) ? jcs_pkg::MODE_STRING
                                                : jcs_pkg::MODE_NORMAL;
        end
      end
    endcase
    if (last) begin
      case (scan_state)
        jcs_pkg::MODE_SLASH: begin
          emit(jcs_pkg::CH_SLASH, jcs_pkg::KIND_BYTE);
          emit(8'h00, jcs_pkg::KIND_END_OK);
        end
        jcs_pkg::MODE_NORMAL: emit(8'h00, jcs_pkg::KIND_END_OK);
        default:              emit(8'h00, jcs_pkg::KIND_END_OPEN);
      endcase
      scan_state = jcs_pkg::MODE_NORMAL;
    end
    if (step_cnt > 0) step_res[step_cnt-1].run_last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_not(logic [7:0] excl);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == excl) ? 8'h71 : b;
  endfunction

  task automatic build_stim();
    logic [7:0] txt [$];
    int         ntok;
    int         len;
    int         cut;
    tok_t       tk;
    dir_tab = '{
      row(8'h00, 1'b0, 1'b1, 2'd1, mk_res(8'h00, jcs_pkg::KIND_BYTE, 1'b1), NO_RES),
      row(8'hFF, 1'b0, 1'b1, 2'd1, mk_res(8'hFF, jcs_pkg::KIND_BYTE, 1'b1), NO_RES),
      row(jcs_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(8'h61,             1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(8'h78,             1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_NL,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_STAR,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b1, 1'b1, 2'd2,
          mk_res(jcs_pkg::CH_SLASH, jcs_pkg::KIND_BYTE, 1'b0),
          mk_res(8'h00, jcs_pkg::KIND_END_OK, 1'b1)),
      row(jcs_pkg::CH_QUOTE, 1'b1, 1'b1, 2'd2,
          mk_res(jcs_pkg::CH_QUOTE, jcs_pkg::KIND_BYTE, 1'b0),
          mk_res(8'h00, jcs_pkg::KIND_END_OPEN, 1'b1)),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b1, 1'b1, 2'd1,
          mk_res(8'h00, jcs_pkg::KIND_END_OPEN, 1'b1), NO_RES),
      row(jcs_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES),
      row(jcs_pkg::CH_STAR,  1'b1, 1'b1, 2'd1,
          mk_res(8'h00, jcs_pkg::KIND_END_OPEN, 1'b1), NO_RES),
      row(8'h78,             1'b1, 1'b1, 2'd2,
          mk_res(8'h78, jcs_pkg::KIND_BYTE, 1'b0),
          mk_res(8'h00, jcs_pkg::KIND_END_OK, 1'b1))
    };
    foreach (dir_tab[i]) stim.push_back(dir_tab[i]);

    while (stim.size() < N_DIR + N_RAND) begin
      txt.delete();
      if ($urandom_range(0, 9) == 0) begin
        // noise text
        len = $urandom_range(1, 12);
        repeat (len) begin
          case ($urandom_range(0, 5))
            0:       txt.push_back(jcs_pkg::CH_SLASH);
            1:       txt.push_back(jcs_pkg::CH_STAR);
            2:       txt.push_back(jcs_pkg::CH_QUOTE);
            3:       txt.push_back(jcs_pkg::CH_NL);
            default: txt.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        ntok = $urandom_range(1, 5);
        repeat (ntok) begin
          tk  = tok_t'($urandom_range(0, 4));
          len = $urandom_range(0, 6);
          case (tk)
            TOK_PLAIN: begin
              repeat (len + 1) txt.push_back(rand_not(jcs_pkg::CH_SLASH));
            end
            TOK_STRING: begin
              txt.push_back(jcs_pkg::CH_QUOTE);
              repeat (len) txt.push_back(rand_not(jcs_pkg::CH_QUOTE));
              txt.push_back(jcs_pkg::CH_QUOTE);
            end
            TOK_LINE: begin
              txt.push_back(jcs_pkg::CH_SLASH);
              txt.push_back(jcs_pkg::CH_SLASH);
              repeat (len) txt.push_back(rand_not(jcs_pkg::CH_NL));
              txt.push_back(jcs_pkg::CH_NL);
            end
            TOK_BLOCK: begin
              txt.push_back(jcs_pkg::CH_SLASH);
              txt.push_back(jcs_pkg::CH_STAR);
              repeat (len) txt.push_back(rand_not(jcs_pkg::CH_SLASH));
              txt.push_back(jcs_pkg::CH_STAR);
              txt.push_back(jcs_pkg::CH_SLASH);
            end
            default: begin
              txt.push_back(jcs_pkg::CH_SLASH);
              txt.push_back(8'($urandom_range(0, 255)));
            end
          endcase
        end
        // broken text: cut short anywhere
        if ($urandom_range(0, 4) == 0 && txt.size() > 1) begin
          cut = $urandom_range(1, txt.size() - 1);
          while (txt.size() > cut) void'(txt.pop_back());
        end
      end
      foreach (txt[i])
        stim.push_back(row(txt[i], i == txt.size() - 1, 1'b0, 2'd0, NO_RES, NO_RES));
    end
  endtask

  // input and output monitor
  always @(posedge clk) begin : mon
    beat_t            cur;
    jcs_pkg::result_t got;
    jcs_pkg::result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        cur = stim[bytes_taken];
        strip_byte(cur.data, cur.last);
        if (cur.typed) begin
          for (int k = 0; k < cur.n; k++) due_results.push_back(cur.res[k]);
        end else begin
          for (int k = 0; k < step_cnt; k++) due_results.push_back(step_res[k]);
        end
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got = mk_res(out_byte, kind, run_last);
        if (due_results.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %h kind %0d last %b",
                   $time, got.out_byte, got.kind, got.run_last);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
            fail_cnt++;
          end
          if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            fail_cnt++;
          end
          if (got.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                     got.run_last);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the block
  initial begin : rx
    int  hold;
    bit  long_done;
    hold      = 0;
    long_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_done && bytes_taken >= 150) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 6);
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin
    build_stim();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < stim.size(); i++) begin
      if (i >= stim.size() - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      in_valid = 1'b1;
      in_byte  = stim[i].data;
      in_last  = stim[i].last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/jcs_pkg.sv
hdl/jcs_scanner.sv
hdl/json_comment_stripper.sv
bench/tb_top.sv
